>>> rtl/lqrs_pkg.sv
`timescale 1ns / 1ps
package lqrs_pkg;

	localparam int DiscW = 34;
	localparam int RadW = 50;
	localparam int SqW = 25;
	localparam int NumW = 33;
	localparam int DvdW = 41;
	localparam int QW = 41;
	localparam int DivW = 16;

	typedef enum logic {
		KIND_LINEAR = 1'b0,
		KIND_QUAD = 1'b1
	} kind_t;

	typedef struct packed {
		logic kind;
		logic signed [15:0] coef_a;
		logic signed [15:0] coef_b;
		logic signed [15:0] coef_c;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] root_plus;
		logic signed [31:0] root_minus;
		logic solvable;
	} out_word_t;

	function automatic logic signed [31:0] sat32(input logic signed [QW:0] v);
		logic signed [31:0] r;
		begin
			if (v > $signed({{(QW - 30){1'b0}}, {31{1'b1}}})) begin
				r = 32'sh7fffffff;
			end else if (v < $signed({{(QW - 30){1'b1}}, {31{1'b0}}})) begin
				r = 32'sh80000000;
			end else begin
				r = v[31:0];
			end
			return r;
		end
	endfunction

endpackage

>>> rtl/lqrs_sqrt.sv
`timescale 1ns / 1ps
module lqrs_sqrt (
	input logic clk,
	input logic en,
	input logic [lqrs_pkg::RadW-1:0] rad,
	output logic [lqrs_pkg::SqW-1:0] root
);
	import lqrs_pkg::*;

	// One result bit per stage, restoring method, with a register after every fifth stage.
	logic [SqW:0] rem_s [SqW+1];
	logic [SqW-1:0] res_s [SqW+1];
	logic [RadW-1:0] rad_s [SqW+1];

	assign rem_s[0] = '0;
	assign res_s[0] = '0;
	assign rad_s[0] = rad;

	for (genvar i = 0; i < SqW; i++) begin : g_st
		logic [SqW+2:0] sh;
		logic [SqW+2:0] trial;
		logic [SqW:0] rem_n;
		logic [SqW-1:0] res_n;
		always_comb begin
			sh = {rem_s[i], rad_s[i][RadW-1-2*i -: 2]};
			trial = {1'b0, res_s[i], 2'b01};
			if (sh >= trial) begin
				rem_n = (SqW + 1)'(sh - trial);
				res_n = {res_s[i][SqW-2:0], 1'b1};
			end else begin
				rem_n = sh[SqW:0];
				res_n = {res_s[i][SqW-2:0], 1'b0};
			end
		end
		if (i % 5 == 4) begin : g_reg
			logic [SqW:0] rem_q;
			logic [SqW-1:0] res_q;
			logic [RadW-1:0] rad_q;
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q <= rem_n;
					res_q <= res_n;
					rad_q <= rad_s[i];
				end
			end
			assign rem_s[i+1] = rem_q;
			assign res_s[i+1] = res_q;
			assign rad_s[i+1] = rad_q;
		end else begin : g_comb
			assign rem_s[i+1] = rem_n;
			assign res_s[i+1] = res_n;
			assign rad_s[i+1] = rad_s[i];
		end
	end

	assign root = res_s[SqW];
endmodule

>>> rtl/lqrs_div.sv
`timescale 1ns / 1ps
module lqrs_div (
	input logic clk,
	input logic en,
	input logic [lqrs_pkg::DvdW-1:0] num,
	input logic [lqrs_pkg::DivW-1:0] den,
	output logic [lqrs_pkg::QW-1:0] quo
);
	import lqrs_pkg::*;

	logic [DivW:0] rem_s [QW+1];
	logic [QW-1:0] q_s [QW+1];
	logic [DvdW-1:0] n_s [QW+1];
	logic [DivW-1:0] d_s [QW+1];

	assign rem_s[0] = '0;
	assign q_s[0] = '0;
	assign n_s[0] = num;
	assign d_s[0] = den;

	for (genvar i = 0; i < QW; i++) begin : g_st
		logic [DivW+1:0] sh;
		logic [DivW:0] rem_n;
		logic [QW-1:0] q_n;
		always_comb begin
			sh = {rem_s[i], n_s[i][DvdW-1-i]};
			if (sh >= (DivW + 2)'(d_s[i])) begin
				rem_n = (DivW + 1)'(sh - (DivW + 2)'(d_s[i]));
				q_n = q_s[i] | (QW'(1) << (QW - 1 - i));
			end else begin
				rem_n = sh[DivW:0];
				q_n = q_s[i];
			end
		end
		if (i % 6 == 5) begin : g_reg
			logic [DivW:0] rem_q;
			logic [QW-1:0] q_q;
			logic [DvdW-1:0] n_q;
			logic [DivW-1:0] d_q;
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q <= rem_n;
					q_q <= q_n;
					n_q <= n_s[i];
					d_q <= d_s[i];
				end
			end
			assign rem_s[i+1] = rem_q;
			assign q_s[i+1] = q_q;
			assign n_s[i+1] = n_q;
			assign d_s[i+1] = d_q;
		end else begin : g_comb
			assign rem_s[i+1] = rem_n;
			assign q_s[i+1] = q_n;
			assign n_s[i+1] = n_s[i];
			assign d_s[i+1] = d_s[i];
		end
	end

	assign quo = q_s[QW];
endmodule

>>> rtl/linear_quadratic_root_solver_unit.sv
`timescale 1ns / 1ps
// Channel | Direction | Payload    | Handshake
// in      | input     | in_word_t  | in_valid / in_stall
// out     | output    | out_word_t | out_valid / out_stall
// One word enters per cycle unless a valid output word stalls. Stages: discriminant,
// five root stages (one register every five root bits), numerator, six divider stages
// (one register every six quotient bits) and the output register.
// Reset clears all valid bits; payload registers are not reset.
// A valid output word under stall freezes the whole pipeline; in_stall follows it.
module linear_quadratic_root_solver_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input lqrs_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_stall,
	output lqrs_pkg::out_word_t out_data
);
	import lqrs_pkg::*;

	localparam int SqLat = SqW / 5;
	localparam int DvLat = QW / 6;
	localparam int Lat = 3 + SqLat + DvLat;

	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	// Stage 1: discriminant.
	logic kind_s1;
	logic signed [15:0] a_s1, b_s1;
	logic signed [DiscW-1:0] disc_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= in_data.kind;
			a_s1 <= in_data.coef_a;
			b_s1 <= in_data.coef_b;
			disc_s1 <= DiscW'(in_data.coef_b * in_data.coef_b)
				- (DiscW'(in_data.coef_a * in_data.coef_c) <<< 2);
		end
	end

	logic [RadW-1:0] rad;
	logic [SqW-1:0] s_root;
	assign rad = disc_s1[DiscW-1] ? '0 : {disc_s1[DiscW-2:0], 17'b0} >> 1;
	lqrs_sqrt u_sqrt (.clk(clk), .en(en), .rad(rad), .root(s_root));

	logic kind_d [SqLat+1];
	logic neg_d [SqLat+1];
	logic signed [15:0] a_d [SqLat+1];
	logic signed [15:0] b_d [SqLat+1];
	assign kind_d[0] = kind_s1;
	assign neg_d[0] = disc_s1[DiscW-1];
	assign a_d[0] = a_s1;
	assign b_d[0] = b_s1;
	for (genvar k = 0; k < SqLat; k++) begin : g_dl
		always_ff @(posedge clk) begin
			if (en) begin
				kind_d[k+1] <= kind_d[k];
				neg_d[k+1] <= neg_d[k];
				a_d[k+1] <= a_d[k];
				b_d[k+1] <= b_d[k];
			end
		end
	end

	// Stage 2: signed numerators and magnitudes.
	logic signed [NumW+8:0] np, nm;
	always_comb begin
		if (kind_d[SqLat] == KIND_LINEAR) begin
			np = -((NumW + 9)'(b_d[SqLat]) <<< 16);
			nm = '0;
		end else begin
			np = ((NumW + 9)'(-(NumW + 9)'(b_d[SqLat]) <<< 8)
				+ (NumW + 9)'(s_root)) <<< 7;
			nm = ((NumW + 9)'(-(NumW + 9)'(b_d[SqLat]) <<< 8)
				- (NumW + 9)'(s_root)) <<< 7;
		end
	end

	logic kind_s2, ok_s2, sp_s2, sm_s2;
	logic [DvdW-1:0] mp_s2, mm_s2;
	logic [DivW-1:0] ma_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_d[SqLat];
			ok_s2 <= (a_d[SqLat] != 0)
				&& !(kind_d[SqLat] == KIND_QUAD && neg_d[SqLat]);
			sp_s2 <= np[NumW+8] ^ a_d[SqLat][15];
			sm_s2 <= nm[NumW+8] ^ a_d[SqLat][15];
			mp_s2 <= DvdW'(np[NumW+8] ? -np : np);
			mm_s2 <= DvdW'(nm[NumW+8] ? -nm : nm);
			ma_s2 <= a_d[SqLat][15] ? DivW'(-a_d[SqLat]) : DivW'(a_d[SqLat]);
		end
	end

	logic [QW-1:0] qp, qm;
	lqrs_div u_dp (.clk(clk), .en(en), .num(mp_s2), .den(ma_s2), .quo(qp));
	lqrs_div u_dm (.clk(clk), .en(en), .num(mm_s2), .den(ma_s2), .quo(qm));

	logic ok_e [DvLat+1];
	logic kind_e [DvLat+1];
	logic sp_e [DvLat+1];
	logic sm_e [DvLat+1];
	assign ok_e[0] = ok_s2;
	assign kind_e[0] = kind_s2;
	assign sp_e[0] = sp_s2;
	assign sm_e[0] = sm_s2;
	for (genvar k = 0; k < DvLat; k++) begin : g_de
		always_ff @(posedge clk) begin
			if (en) begin
				ok_e[k+1] <= ok_e[k];
				kind_e[k+1] <= kind_e[k];
				sp_e[k+1] <= sp_e[k];
				sm_e[k+1] <= sm_e[k];
			end
		end
	end

	logic signed [QW:0] rp, rm;
	assign rp = sp_e[DvLat] ? -$signed({1'b0, qp}) : $signed({1'b0, qp});
	assign rm = sm_e[DvLat] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});

	// Valid bits.
	logic [Lat-1:0] v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[Lat-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.solvable <= ok_e[DvLat];
			out_data.root_plus <= ok_e[DvLat] ? sat32(rp) : '0;
			out_data.root_minus <= (ok_e[DvLat] && kind_e[DvLat] == KIND_QUAD)
				? sat32(rm) : '0;
		end
	end
	assign out_valid = v_q[Lat-1];

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output changed under stall");
	a_unsolv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.solvable |-> out_data.root_plus == 0)
		else $error("unsolvable word carries a root");
	a_stall_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow the output stall");
endmodule

>>> verif/lqrs_checker.sv
`timescale 1ns / 1ps
module lqrs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input lqrs_pkg::in_word_t in_data,
	input logic out_valid,
	input logic out_stall,
	input lqrs_pkg::out_word_t out_data,
	output int fails,
	output int pending
);
	import lqrs_pkg::*;

	out_word_t roots_q[$];
	int n_in;
	int n_out;
	int n_unsolvable;
	int n_sat;

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] rem;
		logic [63:0] b;
		res = 0;
		rem = v;
		b = 64'd1 << 62;
		while (b > rem) b = b >> 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] clamp_q16(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic out_word_t solve_roots(input in_word_t w);
		out_word_t r;
		longint a;
		longint b;
		longint c;
		longint disc;
		longint s;
		longint nb;
		a = w.coef_a;
		b = w.coef_b;
		c = w.coef_c;
		r = '0;
		if (a != 0) begin
			if (w.kind == KIND_LINEAR) begin
				r.root_plus = clamp_q16((-b * 65536) / a);
				r.solvable = 1'b1;
			end else begin
				disc = b * b - 4 * a * c;
				if (disc >= 0) begin
					s = int_sqrt(64'(disc) << 16);
					nb = -b * 256;
					r.root_plus = clamp_q16(((nb + s) * 128) / a);
					r.root_minus = clamp_q16(((nb - s) * 128) / a);
					r.solvable = 1'b1;
				end
			end
		end
		return r;
	endfunction

	assign pending = roots_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		int errs;
		if (!arst_n) begin
			fails <= 0;
			n_in <= 0;
			n_out <= 0;
			n_unsolvable <= 0;
			n_sat <= 0;
		end else begin
			errs = 0;
			if (in_valid && !in_stall) begin
				e = solve_roots(in_data);
				roots_q.push_back(e);
				n_in <= n_in + 1;
				if (!e.solvable) n_unsolvable <= n_unsolvable + 1;
				if (e.root_plus == 32'sh7fffffff || e.root_plus == 32'sh80000000)
					n_sat <= n_sat + 1;
			end
			if (out_valid && !out_stall) begin
				n_out <= n_out + 1;
				if (roots_q.size() == 0) begin
					$display("%0t: unexpected word %h", $time, out_data);
					errs = errs + 1;
				end else begin
					e = roots_q.pop_front();
					if (e.root_plus !== out_data.root_plus) begin
						$display("%0t: root_plus exp %h got %h", $time, e.root_plus,
							out_data.root_plus);
						errs = errs + 1;
					end
					if (e.root_minus !== out_data.root_minus) begin
						$display("%0t: root_minus exp %h got %h", $time, e.root_minus,
							out_data.root_minus);
						errs = errs + 1;
					end
					if (e.solvable !== out_data.solvable) begin
						$display("%0t: solvable exp %b got %b", $time, e.solvable,
							out_data.solvable);
						errs = errs + 1;
					end
				end
			end
			fails <= fails + errs;
		end
	end
endmodule

>>> verif/tb_linear_quadratic_root_solver_unit.sv
`timescale 1ns / 1ps
module tb_linear_quadratic_root_solver_unit;
	import lqrs_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_word_t in_data;
	logic out_valid;
	logic out_stall;
	out_word_t out_data;
	int fails;
	int pending;
	longint cycles;
	int burst;

	linear_quadratic_root_solver_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	lqrs_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fails(fails), .pending(pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("linear_quadratic_root_solver_unit: mismatch");
			$finish;
		end
	end

	always @(negedge clk) begin
		int m;
		m = (cycles / 300) % 4;
		if (m == 0) out_stall <= 1'b0;
		else if (m == 1) out_stall <= ($urandom_range(0, 3) == 0);
		else if (m == 2) out_stall <= ($urandom_range(0, 1) == 0);
		else out_stall <= ($urandom_range(0, 9) < 8);
	end

	function automatic logic signed [15:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'($signed($urandom_range(0, 1023)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_word(input in_word_t w);
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		burst = burst - 1;
		if (burst <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst = $urandom_range(1, 20);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	initial begin
		in_word_t w;
		logic signed [15:0] ex[4];
		cycles = 0;
		burst = 8;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		ex = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001};
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (ex[i]) begin
			w.kind = (i % 2 == 0) ? KIND_LINEAR : KIND_QUAD;
			w.coef_a = ex[i]; w.coef_b = ex[3 - i]; w.coef_c = ex[(i + 1) % 4];
			send_word(w);
			w.kind = ~w.kind;
			send_word(w);
		end
		w = '{KIND_QUAD, 16'sh0100, 16'sh0000, 16'sh0100};
		send_word(w);
		w = '{KIND_QUAD, 16'sh0100, 16'sh0200, 16'sh0100};
		send_word(w);
		w = '{KIND_QUAD, 16'sh0001, 16'sh7fff, 16'sh8000};
		send_word(w);
		w = '{KIND_LINEAR, 16'sh0001, 16'sh8000, 16'sh0000};
		send_word(w);
		w = '{KIND_QUAD, 16'sh0000, 16'sh0100, 16'sh0100};
		send_word(w);
		w = '{KIND_QUAD, 16'shffff, 16'sh8000, 16'sh7fff};
		send_word(w);
		drain();
		for (int i = 0; i < 700; i++) begin
			w.kind = kind_t'($urandom_range(0, 1));
			w.coef_a = pick_coef();
			w.coef_b = pick_coef();
			w.coef_c = pick_coef();
			send_word(w);
			if (i == 350) drain();
		end
		drain();
		$display("Ran %0d words, %0d unsolvable, %0d saturated root_plus.",
			i_checker.n_in, i_checker.n_unsolvable, i_checker.n_sat);
		if (fails == 0) begin
			$display("linear_quadratic_root_solver_unit: match");
		end else begin
			$display("linear_quadratic_root_solver_unit: mismatch");
		end
		$finish;
	end
endmodule
